>>> sv/sti_pkg.sv
// shared types and constants of the sphere triangle index generator
// no dependencies
package sti_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned IndexW = 16;
  localparam int unsigned CfgIndexW = 8;

  localparam logic [CountW-1:0] MinDivisions = CountW'(3);
  localparam logic [CountW-1:0] MaxDivisions = CountW'(255);

  localparam logic [CfgIndexW-1:0] CfgSliceCount = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] CfgStackCount = CfgIndexW'(1);

  typedef struct packed {
    logic [CountW-1:0] slice_count;
    logic [CountW-1:0] stack_count;
  } cfg_t;

  typedef struct packed {
    logic [IndexW-1:0] index_a;
    logic [IndexW-1:0] index_b;
    logic [IndexW-1:0] index_c;
    logic              last_triangle;
  } tri_t;

endpackage

>>> sv/sphere_triangle_index_generator.sv
// top level of the sphere triangle index generator: handshakes and result register
// depends on sti_pkg, sti_cfg and sti_core
//
// Emits the triangle index list of a latitude-longitude sphere, one triangle per
// input transfer. The input channel carries restart_i: 1 begins again at the first
// top-fan triangle, 0 moves on to the next triangle. Each output transfer carries
// three 16-bit vertex indices and last_triangle, set on the final bottom-fan
// triangle, after which the walk starts over by itself.
// The configuration channel writes slice_count (index 0) and stack_count
// (index 1); data is saturated to 3..255, other indices are ignored. cfg_ready_o
// is always high. Write only while no triangle is outstanding.
// A result is valid in the cycle after its input transfer. Unless stalled, one
// triangle can be taken per cycle: the step is one pass of counter and adder logic
// into the result register. While the receiver stalls the result register holds
// and in_ready_o drops; it rises again in the cycle the result is taken.
// Reset clears the walk to the first top-fan triangle, sets both counts to 3 and
// empties the result register.
module sphere_triangle_index_generator
  import sti_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CountW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IndexW-1:0]    index_a_o,
  output logic [IndexW-1:0]    index_b_o,
  output logic [IndexW-1:0]    index_c_o,
  output logic                 last_triangle_o
);

  cfg_t cfg;
  tri_t tri_next;
  tri_t tri_q;
  logic out_valid_q, out_valid_d;
  logic in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  sti_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sti_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_xfer),
    .restart_i (restart_i),
    .cfg_i     (cfg),
    .tri_o     (tri_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tri_q <= tri_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign index_a_o       = tri_q.index_a;
  assign index_b_o       = tri_q.index_b;
  assign index_c_o       = tri_q.index_c;
  assign last_triangle_o = tri_q.last_triangle;

  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("input transfer did not produce a result");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_xfer)
    else $error("input taken while result register full and stalled");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !in_xfer |=> !out_valid_q)
    else $error("result shown twice");

endmodule

>>> sv/sti_cfg.sv
// slice and stack count registers with saturation to the legal range
// depends on sti_pkg
module sti_cfg
  import sti_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CountW-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  logic [CountW-1:0] slice_count_q, slice_count_d;
  logic [CountW-1:0] stack_count_q, stack_count_d;
  logic [CountW-1:0] clamped;

  always_comb begin
    if (cfg_data_i < MinDivisions) begin
      clamped = MinDivisions;
    end else if (cfg_data_i > MaxDivisions) begin
      clamped = MaxDivisions;
    end else begin
      clamped = cfg_data_i;
    end
  end

  always_comb begin
    slice_count_d = slice_count_q;
    stack_count_d = stack_count_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSliceCount: slice_count_d = clamped;
        CfgStackCount: stack_count_d = clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= MinDivisions;
      stack_count_q <= MinDivisions;
    end else begin
      slice_count_q <= slice_count_d;
      stack_count_q <= stack_count_d;
    end
  end

  assign cfg_o.slice_count = slice_count_q;
  assign cfg_o.stack_count = stack_count_q;

  a_slice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slice_count_q >= MinDivisions && slice_count_q <= MaxDivisions)
    else $error("slice count out of range");

  a_stack_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_count_q >= MinDivisions && stack_count_q <= MaxDivisions)
    else $error("stack count out of range");

  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i != CfgSliceCount && cfg_index_i != CfgStackCount
    |=> $stable(slice_count_q) && $stable(stack_count_q))
    else $error("write to unknown register changed a count");

endmodule

>>> sv/sti_core.sv
// mesh walk state and per-triangle index logic, one triangle per step
// depends on sti_pkg
module sti_core
  import sti_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic restart_i,
  input  cfg_t cfg_i,
  output tri_t tri_o
);

  logic [CountW-1:0] ring_pos_q, ring_pos_d;
  logic [CountW-1:0] seg_pos_q, seg_pos_d;
  logic              second_half_q, second_half_d;
  logic [IndexW-1:0] ring_base_q, ring_base_d;
  logic              bottom_fan_q, bottom_fan_d;

  logic [CountW-1:0] ring_pos;
  logic [CountW-1:0] k;
  logic              second_half;
  logic [IndexW-1:0] upper;
  logic              bottom_fan;

  logic [CountW:0]   k_inc;
  logic [CountW:0]   ring_inc;
  logic              ring_done;
  logic [CountW-1:0] nxt;
  logic [IndexW-1:0] lower;
  logic [IndexW-1:0] slice_ext;
  logic [IndexW-1:0] k_ext;
  logic [IndexW-1:0] nxt_ext;

  // restart takes effect before the triangle is formed
  always_comb begin
    if (restart_i) begin
      ring_pos    = '0;
      k           = '0;
      second_half = 1'b0;
      upper       = IndexW'(1);
      bottom_fan  = 1'b0;
    end else begin
      ring_pos    = ring_pos_q;
      k           = seg_pos_q;
      second_half = second_half_q;
      upper       = ring_base_q;
      bottom_fan  = bottom_fan_q;
    end
  end

  always_comb begin
    k_inc     = {1'b0, k} + (CountW+1)'(1);
    ring_inc  = {1'b0, ring_pos} + (CountW+1)'(2);
    ring_done = k_inc >= {1'b0, cfg_i.slice_count};
    nxt       = ring_done ? '0 : k_inc[CountW-1:0];
    slice_ext = IndexW'(cfg_i.slice_count);
    k_ext     = IndexW'(k);
    nxt_ext   = IndexW'(nxt);
    lower     = upper + slice_ext;
  end

  always_comb begin
    ring_pos_d          = ring_pos;
    seg_pos_d           = ring_done ? '0 : k_inc[CountW-1:0];
    second_half_d       = second_half;
    ring_base_d         = upper;
    bottom_fan_d        = bottom_fan;
    tri_o.last_triangle = 1'b0;

    if (bottom_fan) begin
      tri_o.index_a = upper + k_ext;
      tri_o.index_b = upper + nxt_ext;
      tri_o.index_c = lower;
      if (ring_done) begin
        tri_o.last_triangle = 1'b1;
        ring_pos_d          = '0;
        second_half_d       = 1'b0;
        ring_base_d         = IndexW'(1);
        bottom_fan_d        = 1'b0;
      end
    end else if (ring_pos == '0) begin
      // top fan around the north pole
      tri_o.index_a = '0;
      tri_o.index_b = upper + nxt_ext;
      tri_o.index_c = upper + k_ext;
      if (ring_done) begin
        ring_pos_d = CountW'(1);
      end
    end else if (!second_half) begin
      tri_o.index_a = upper + k_ext;
      tri_o.index_b = upper + nxt_ext;
      tri_o.index_c = lower + k_ext;
      second_half_d = 1'b1;
      seg_pos_d     = k;
    end else begin
      tri_o.index_a = upper + nxt_ext;
      tri_o.index_b = lower + nxt_ext;
      tri_o.index_c = lower + k_ext;
      second_half_d = 1'b0;
      if (ring_done) begin
        ring_base_d = lower;
        if (ring_inc >= {1'b0, cfg_i.stack_count}) begin
          bottom_fan_d = 1'b1;
        end else begin
          ring_pos_d = ring_inc[CountW-1:0] - CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_pos_q    <= '0;
      seg_pos_q     <= '0;
      second_half_q <= 1'b0;
      ring_base_q   <= IndexW'(1);
      bottom_fan_q  <= 1'b0;
    end else if (step_i) begin
      ring_pos_q    <= ring_pos_d;
      seg_pos_q     <= seg_pos_d;
      second_half_q <= second_half_d;
      ring_base_q   <= ring_base_d;
      bottom_fan_q  <= bottom_fan_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tri_o.last_triangle
    |=> ring_base_q == IndexW'(1) && seg_pos_q == '0 && !bottom_fan_q && ring_pos_q == '0)
    else $error("mesh did not start over after the last triangle");

  a_fan_no_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_pos_q == '0 || bottom_fan_q) |-> !second_half_q)
    else $error("second half of a quad flagged inside a fan");

  a_seg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_pos_q < MaxDivisions)
    else $error("segment position beyond the largest ring");

endmodule
